/* rtl/core/avi_pkg.sv */
// Shared types and constants of the attitude and velocity integrator.
// Item structs, angle constants, the arctangent table and the trig result struct.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package avi_pkg;

  typedef struct packed {
    logic        [24:0] tick_dt;
    logic signed [31:0] roll_rate_cmd;
    logic signed [31:0] pitch_rate_cmd;
    logic signed [31:0] yaw_rate_cmd;
    logic signed [31:0] fwd_accel;
    logic signed [31:0] side_accel;
    logic signed [31:0] down_accel;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] roll_angle;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] yaw_angle;
    logic signed [31:0] body_rate_p;
    logic signed [31:0] body_rate_q;
    logic signed [31:0] body_rate_r;
    logic signed [31:0] vel_north;
    logic signed [31:0] vel_east;
    logic signed [31:0] vel_down;
  } out_item_t;

  // Sine and cosine in signed Q4.30, with a one-cycle done strobe.
  typedef struct packed {
    logic               done;
    logic signed [33:0] sin_v;
    logic signed [33:0] cos_v;
  } trig_res_t;

  localparam logic signed [31:0] ANG_PI      = 32'sd843314857;
  localparam logic signed [31:0] ANG_HALF_PI = 32'sd421657428;
  localparam logic        [31:0] CORDIC_GAIN_Q32 = 32'd2608131496;

  // Arctangent of 2^-i in Q4.28, truncated.
  function automatic logic [31:0] atan_q28(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd210828714;
      5'd1:  v = 32'd124459457;
      5'd2:  v = 32'd65760959;
      5'd3:  v = 32'd33381289;
      5'd4:  v = 32'd16755421;
      5'd5:  v = 32'd8385878;
      5'd6:  v = 32'd4193962;
      5'd7:  v = 32'd2097109;
      5'd8:  v = 32'd1048570;
      5'd9:  v = 32'd524287;
      5'd10: v = 32'd262143;
      5'd11: v = 32'd131071;
      5'd12: v = 32'd65535;
      5'd13: v = 32'd32767;
      5'd14: v = 32'd16383;
      5'd15: v = 32'd8191;
      5'd16: v = 32'd4095;
      5'd17: v = 32'd2047;
      5'd18: v = 32'd1023;
      5'd19: v = 32'd511;
      5'd20: v = 32'd255;
      5'd21: v = 32'd127;
      5'd22: v = 32'd63;
      5'd23: v = 32'd31;
      5'd24: v = 32'd15;
      5'd25: v = 32'd7;
      5'd26: v = 32'd3;
      5'd27: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/avi_mul.sv */
// Shared signed multiplier with a registered product and round-to-nearest output.
// Depends on avi_pkg only through the common house style.
`timescale 1ns / 1ps

module avi_mul (
  input  logic               clk,
  input  logic signed [35:0] op_a,
  input  logic signed [35:0] op_b,
  input  logic               sel_q25,
  output logic signed [47:0] rnd_prod
);
  import avi_pkg::*;

  logic signed [71:0] prod_r;
  logic               sel_q25_r;
  logic signed [71:0] rounded;

  always_ff @(posedge clk) begin
    prod_r    <= op_a * op_b;
    sel_q25_r <= sel_q25;
  end

  // Ties round towards plus infinity.
  assign rounded = sel_q25_r ? ((prod_r + 72'sd16777216) >>> 25)
                             : ((prod_r + 72'sd536870912) >>> 30);
  assign rnd_prod = rounded[47:0];

endmodule

/* rtl/core/avi_cordic.sv */
// Iterative rotation-mode CORDIC giving sine and cosine of one Q4.28 angle.
// Depends on avi_pkg for the arctangent table, gain and result struct.
`timescale 1ns / 1ps

module avi_cordic #(
  parameter int WORD_WIDTH      = 32,
  parameter int TRIG_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] angle,
  output avi_pkg::trig_res_t res
);
  import avi_pkg::*;

  localparam int XW    = WORD_WIDTH + 2;
  localparam int F     = WORD_WIDTH - 2;
  localparam int IW    = $clog2(TRIG_ITERATIONS);
  localparam int SH_UP = (F >= 32) ? F - 32 : 0;
  localparam int SH_DN = (F >= 32) ? 0 : 32 - F;
  localparam int SH_DH = (SH_DN > 0) ? SH_DN - 1 : 0;
  localparam logic [63:0] RND_IN = (SH_DN > 0) ? (64'd1 << SH_DH) : 64'd0;
  localparam logic [63:0] X_INIT = ((64'(CORDIC_GAIN_Q32) + RND_IN) >> SH_DN) << SH_UP;
  localparam int RS = (F > 30) ? F - 30 : 0;
  localparam int LS = (F < 30) ? 30 - F : 0;
  localparam int RH = (RS > 0) ? RS - 1 : 0;
  localparam logic signed [63:0] RND_OUT = (RS > 0) ? (64'sd1 <<< RH) : 64'sd0;

  logic signed [XW-1:0] x_r, y_r, dx, dy;
  logic signed [33:0]   z_r, z0, step_ang;
  logic signed [33:0]   ang_w;
  logic [IW-1:0]        i_r;
  logic                 busy_r, done_r, neg_r, neg0;
  logic signed [63:0]   x_o, y_o;

  always_comb begin
    ang_w = 34'(angle);
    neg0  = 1'b0;
    z0    = ang_w;
    if (angle > ANG_HALF_PI) begin
      z0   = ang_w - 34'(ANG_PI);
      neg0 = 1'b1;
    end else if (angle < -ANG_HALF_PI) begin
      z0   = ang_w + 34'(ANG_PI);
      neg0 = 1'b1;
    end
  end

  assign dx       = y_r >>> i_r;
  assign dy       = x_r >>> i_r;
  assign step_ang = $signed({2'b00, atan_q28(5'(i_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && i_r == IW'(TRIG_ITERATIONS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= XW'(X_INIT);
      y_r   <= '0;
      z_r   <= z0;
      neg_r <= neg0;
      i_r   <= '0;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - step_ang;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + step_ang;
      end
      i_r <= i_r + 1'b1;
    end
  end

  assign x_o = ((64'(x_r) + RND_OUT) >>> RS) <<< LS;
  assign y_o = ((64'(y_r) + RND_OUT) >>> RS) <<< LS;

  assign res.done  = done_r;
  assign res.sin_v = neg_r ? -y_o[33:0] : y_o[33:0];
  assign res.cos_v = neg_r ? -x_o[33:0] : x_o[33:0];

endmodule

/* rtl/core/attitude_velocity_integrator_step_core.sv */
// Top level of the attitude and velocity integrator: sequencer, state and output stage.
// Depends on avi_pkg, avi_mul (shared multiplier) and avi_cordic (sine and cosine).
// Channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+----------------------
// in        | in        | in_valid / in_ready      | in_item (in_item_t)
// out       | out       | out_valid / out_ready    | out_item (out_item_t)
// cfg       | in        | cfg_wr_en, no wait       | cfg_wr_data (31 bit)
//
// An item passes through the accepting state, the 34 passes through the single
// multiplier (each an issue and a write-back), with the three CORDIC runs, one
// angle after the other, between the integration and the rotation passes, and
// the state that loads the output register.
// Reset is synchronous and active low; it clears all angles, held rates,
// velocities and the held step. A finished item waits in the output register
// while the next item is already accepted and worked on.
`timescale 1ns / 1ps

module attitude_velocity_integrator_step_core #(
  parameter int WORD_WIDTH      = 32,
  parameter int TRIG_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  avi_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output avi_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic [30:0]        cfg_wr_data
);
  import avi_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ISSUE   = 6'b000010,
    S_WB      = 6'b000100,
    S_TRIG_GO = 6'b001000,
    S_TRIG_WT = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    BASE_ZERO, BASE_ACC, BASE_RATE0, BASE_ANG, BASE_VEL
  } base_t;

  typedef enum logic [4:0] {
    DST_NONE, DST_ANG, DST_VEL, DST_T, DST_L1, DST_L2, DST_M1, DST_M2, DST_M3,
    DST_N1, DST_N2, DST_N3, DST_P, DST_Q, DST_R, DST_VN, DST_VE, DST_VD
  } dst_t;

  localparam logic [5:0] LAST_INTEG = 6'd5;
  localparam logic [5:0] FIRST_ROT  = 6'd6;
  localparam logic [5:0] LAST_STEP  = 6'd33;

  state_t state_r, state_nxt;
  logic [5:0] step_r;
  logic [1:0] trig_idx_r;
  in_item_t   item_r;

  logic signed [31:0] ang_r [3];
  logic signed [31:0] hrate_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] hacc_r [3];
  logic        [24:0] ls_r;
  logic signed [33:0] sin_r [3];
  logic signed [33:0] cos_r [3];
  logic signed [47:0] acc_r;
  logic signed [35:0] t_r, l1_r, l2_r, m1_r, m2_r, m3_r, n1_r, n2_r, n3_r;
  logic signed [31:0] p_r, q_r, r_r, vn_r, ve_r, vd_r;
  out_item_t          out_item_r;
  logic               out_valid_r;

  logic [1:0]         step_idx, sel_idx;
  logic signed [31:0] rate_k, accel_k;
  logic signed [35:0] integ_a, op_a, op_b;
  logic               neg, sel_q25;
  base_t              base;
  dst_t               dst;
  logic signed [47:0] rnd_prod, base_v, sum_v;
  trig_res_t          trig;
  logic               out_free;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7fffffff;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Trig results by name: roll (phi), pitch (theta), yaw (psi).
  logic signed [33:0] sph, cph, sth, cth, sps, cps;
  assign sph = sin_r[0];
  assign cph = cos_r[0];
  assign sth = sin_r[1];
  assign cth = cos_r[1];
  assign sps = sin_r[2];
  assign cps = cos_r[2];

  // Angle steps 0 to 2 and velocity steps 3 to 5 both map to indices 0 to 2.
  assign step_idx = (step_r < 6'd3) ? step_r[1:0] : 2'(step_r - 6'd3);
  assign sel_idx  = (state_r == S_TRIG_GO || state_r == S_TRIG_WT) ? trig_idx_r : step_idx;

  always_comb begin
    case (sel_idx)
      2'd0: begin
        rate_k  = item_r.roll_rate_cmd;
        accel_k = item_r.fwd_accel;
      end
      2'd1: begin
        rate_k  = item_r.pitch_rate_cmd;
        accel_k = item_r.side_accel;
      end
      default: begin
        rate_k  = item_r.yaw_rate_cmd;
        accel_k = item_r.down_accel;
      end
    endcase
  end

  // Adams-Bashforth weight: three times the new value less the held one.
  always_comb begin
    if (step_r < 6'd3)
      integ_a = (36'(rate_k) <<< 1) + 36'(rate_k) - 36'(hrate_r[sel_idx]);
    else
      integ_a = (36'(accel_k) <<< 1) + 36'(accel_k) - 36'(hacc_r[sel_idx]);
  end

  // Microprogram: operands, accumulator base, sign and destination of each step.
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    neg     = 1'b0;
    base    = BASE_ZERO;
    dst     = DST_NONE;
    sel_q25 = 1'b0;
    case (step_r)
      6'd0, 6'd1, 6'd2: begin
        op_a = integ_a; op_b = 36'(ls_r); sel_q25 = 1'b1;
        base = BASE_ANG; dst = DST_ANG;
      end
      6'd3, 6'd4, 6'd5: begin
        op_a = integ_a; op_b = 36'(ls_r); sel_q25 = 1'b1;
        base = BASE_VEL; dst = DST_VEL;
      end
      6'd6:  begin op_a = 36'(cth); op_b = 36'(cps); dst = DST_L1; end
      6'd7:  begin op_a = 36'(cth); op_b = 36'(sps); dst = DST_L2; end
      6'd8:  begin op_a = 36'(sph); op_b = 36'(sth); dst = DST_T; end
      6'd9:  begin op_a = t_r; op_b = 36'(cps); end
      6'd10: begin
        op_a = 36'(cph); op_b = 36'(sps); base = BASE_ACC; neg = 1'b1; dst = DST_M1;
      end
      6'd11: begin op_a = t_r; op_b = 36'(sps); end
      6'd12: begin op_a = 36'(cph); op_b = 36'(cps); base = BASE_ACC; dst = DST_M2; end
      6'd13: begin op_a = 36'(sph); op_b = 36'(cth); dst = DST_M3; end
      6'd14: begin op_a = 36'(cph); op_b = 36'(sth); dst = DST_T; end
      6'd15: begin op_a = t_r; op_b = 36'(cps); end
      6'd16: begin op_a = 36'(sph); op_b = 36'(sps); base = BASE_ACC; dst = DST_N1; end
      6'd17: begin op_a = t_r; op_b = 36'(sps); end
      6'd18: begin
        op_a = 36'(sph); op_b = 36'(cps); base = BASE_ACC; neg = 1'b1; dst = DST_N2;
      end
      6'd19: begin op_a = 36'(cph); op_b = 36'(cth); dst = DST_N3; end
      6'd20: begin
        op_a = 36'(sth); op_b = 36'(item_r.yaw_rate_cmd);
        base = BASE_RATE0; neg = 1'b1; dst = DST_P;
      end
      6'd21: begin op_a = 36'(cph); op_b = 36'(item_r.pitch_rate_cmd); end
      6'd22: begin
        op_a = m3_r; op_b = 36'(item_r.yaw_rate_cmd); base = BASE_ACC; dst = DST_Q;
      end
      6'd23: begin op_a = -36'(sph); op_b = 36'(item_r.pitch_rate_cmd); end
      6'd24: begin
        op_a = n3_r; op_b = 36'(item_r.yaw_rate_cmd); base = BASE_ACC; dst = DST_R;
      end
      6'd25: begin op_a = l1_r; op_b = 36'(vel_r[0]); end
      6'd26: begin op_a = m1_r; op_b = 36'(vel_r[1]); base = BASE_ACC; end
      6'd27: begin op_a = n1_r; op_b = 36'(vel_r[2]); base = BASE_ACC; dst = DST_VN; end
      6'd28: begin op_a = l2_r; op_b = 36'(vel_r[0]); end
      6'd29: begin op_a = m2_r; op_b = 36'(vel_r[1]); base = BASE_ACC; end
      6'd30: begin op_a = n2_r; op_b = 36'(vel_r[2]); base = BASE_ACC; dst = DST_VE; end
      6'd31: begin op_a = -36'(sth); op_b = 36'(vel_r[0]); end
      6'd32: begin op_a = m3_r; op_b = 36'(vel_r[1]); base = BASE_ACC; end
      6'd33: begin op_a = n3_r; op_b = 36'(vel_r[2]); base = BASE_ACC; dst = DST_VD; end
      default: begin
        op_a = '0;
      end
    endcase
  end

  avi_mul u_mul (
    .clk      (clk),
    .op_a     (op_a),
    .op_b     (op_b),
    .sel_q25  (sel_q25),
    .rnd_prod (rnd_prod)
  );

  avi_cordic #(
    .WORD_WIDTH      (WORD_WIDTH),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_TRIG_GO),
    .angle (ang_r[sel_idx]),
    .res   (trig)
  );

  always_comb begin
    case (base)
      BASE_ACC:   base_v = acc_r;
      BASE_RATE0: base_v = 48'(item_r.roll_rate_cmd);
      BASE_ANG:   base_v = 48'(ang_r[sel_idx]);
      BASE_VEL:   base_v = 48'(vel_r[sel_idx]);
      default:    base_v = '0;
    endcase
    sum_v = neg ? base_v - rnd_prod : base_v + rnd_prod;
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_ISSUE;
      S_ISSUE:   state_nxt = S_WB;
      S_WB: begin
        if (step_r == LAST_INTEG) state_nxt = S_TRIG_GO;
        else if (step_r == LAST_STEP) state_nxt = S_DONE;
        else state_nxt = S_ISSUE;
      end
      S_TRIG_GO: state_nxt = S_TRIG_WT;
      S_TRIG_WT: begin
        if (trig.done) state_nxt = (trig_idx_r == 2'd2) ? S_ISSUE : S_TRIG_GO;
      end
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Sequencing counters, held item, trig results, rotation scratch and output registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        item_r <= in_item;
        step_r <= '0;
      end
      S_WB: begin
        acc_r <= sum_v;
        if (step_r == LAST_INTEG) trig_idx_r <= '0;
        else step_r <= step_r + 6'd1;
        case (dst)
          DST_T:  t_r  <= sum_v[35:0];
          DST_L1: l1_r <= sum_v[35:0];
          DST_L2: l2_r <= sum_v[35:0];
          DST_M1: m1_r <= sum_v[35:0];
          DST_M2: m2_r <= sum_v[35:0];
          DST_M3: m3_r <= sum_v[35:0];
          DST_N1: n1_r <= sum_v[35:0];
          DST_N2: n2_r <= sum_v[35:0];
          DST_N3: n3_r <= sum_v[35:0];
          DST_P:  p_r  <= sat32(sum_v);
          DST_Q:  q_r  <= sat32(sum_v);
          DST_R:  r_r  <= sat32(sum_v);
          DST_VN: vn_r <= sat32(sum_v);
          DST_VE: ve_r <= sat32(sum_v);
          DST_VD: vd_r <= sat32(sum_v);
          default: ;
        endcase
      end
      S_TRIG_WT: begin
        if (trig.done) begin
          sin_r[trig_idx_r] <= trig.sin_v;
          cos_r[trig_idx_r] <= trig.cos_v;
          trig_idx_r        <= trig_idx_r + 2'd1;
          if (trig_idx_r == 2'd2) step_r <= FIRST_ROT;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_item_r.roll_angle  <= ang_r[0];
          out_item_r.pitch_angle <= ang_r[1];
          out_item_r.yaw_angle   <= ang_r[2];
          out_item_r.body_rate_p <= p_r;
          out_item_r.body_rate_q <= q_r;
          out_item_r.body_rate_r <= r_r;
          out_item_r.vel_north   <= vn_r;
          out_item_r.vel_east    <= ve_r;
          out_item_r.vel_down    <= vd_r;
        end
      end
      default: ;
    endcase
  end

  // Integrator state. Pitch is clamped one LSB inside a right angle; roll and
  // yaw jump to the opposite limit once they pass a half turn.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        ang_r[k]   <= '0;
        hrate_r[k] <= '0;
        vel_r[k]   <= '0;
        hacc_r[k]  <= '0;
      end
      ls_r <= '0;
    end else begin
      if (state_r == S_WB && dst == DST_ANG) begin
        if (sel_idx == 2'd1) begin
          if (sum_v >= 48'(ANG_HALF_PI)) ang_r[sel_idx] <= ANG_HALF_PI - 32'sd1;
          else if (sum_v <= -48'(ANG_HALF_PI)) ang_r[sel_idx] <= 32'sd1 - ANG_HALF_PI;
          else ang_r[sel_idx] <= sum_v[31:0];
        end else begin
          if (sum_v > 48'(ANG_PI)) ang_r[sel_idx] <= -ANG_PI;
          else if (sum_v < -48'(ANG_PI)) ang_r[sel_idx] <= ANG_PI;
          else ang_r[sel_idx] <= sum_v[31:0];
        end
      end
      if (state_r == S_WB && dst == DST_VEL) vel_r[sel_idx] <= sat32(sum_v);
      if (state_r == S_DONE && out_free) begin
        hrate_r[0] <= item_r.roll_rate_cmd;
        hrate_r[1] <= item_r.pitch_rate_cmd;
        hrate_r[2] <= item_r.yaw_rate_cmd;
        hacc_r[0]  <= item_r.fwd_accel;
        hacc_r[1]  <= item_r.side_accel;
        hacc_r[2]  <= item_r.down_accel;
        ls_r       <= item_r.tick_dt;
      end
      // Writing the forward speed loads the forward body velocity at once.
      if (cfg_wr_en) vel_r[0] <= $signed({1'b0, cfg_wr_data});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/core/avi_checker.sv */
// Port-level checks for the attitude and velocity integrator, bound to the top level.
// Depends on avi_pkg for the item types and angle limits.
`timescale 1ns / 1ps

module avi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input avi_pkg::out_item_t out_item
);
  import avi_pkg::*;

  // A waiting result item holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // An accepted item keeps the block busy for the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready directly after accepting an item");

  a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.pitch_angle < ANG_HALF_PI &&
                  out_item.pitch_angle > -ANG_HALF_PI)
    else $error("pitch outside its clamp");

  a_roll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.roll_angle <= ANG_PI && out_item.roll_angle >= -ANG_PI &&
                  out_item.yaw_angle <= ANG_PI && out_item.yaw_angle >= -ANG_PI)
    else $error("roll or yaw outside a half turn");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind attitude_velocity_integrator_step_core avi_checker u_avi_checker (.*);
